@@ design/fpa_pkg.sv @@
// Shared types, constants and helpers for the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 8;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int DIV_BPS   = 2;
    localparam int DIV_STG   = (NUM_BITS + DIV_BPS - 1) / DIV_BPS;
    localparam int NUM_PAD   = DIV_STG * DIV_BPS;
    localparam int SAT_W     = 2 * WORD_BITS + 1;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic        [WORD_BITS-1:0] t_mag;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
        OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
    } t_op;

    // divider state: partial remainder, numerator/quotient shifter, divisor
    typedef struct packed {
        t_mag               rem;
        logic [NUM_PAD-1:0] sh;
        t_mag               den;
    } t_div;

    typedef struct packed {
        t_op   op;
        logic  neg;
        logic  cmp;
        logic  ov;
        logic  dz;
        t_word value;
    } t_carry;

    typedef struct packed {
        t_word value;
        logic  ov;
    } t_sat;

    function automatic t_mag mag_of(input t_word v);
        t_mag m;
        m = v[WORD_BITS-1] ? t_mag'(~v + 1'b1) : t_mag'(v);
        return m;
    endfunction

    // magnitude plus sign to saturated signed word
    function automatic t_sat sat_mag(input logic [SAT_W-1:0] mag, input logic neg);
        logic [SAT_W-1:0] lim;
        logic [SAT_W-1:0] m;
        t_sat             s;
        lim     = SAT_W'({1'b0, {(WORD_BITS-1){1'b1}}}) + SAT_W'(neg);
        s.ov    = mag > lim;
        m       = s.ov ? lim : mag;
        s.value = neg ? t_word'(~m[WORD_BITS-1:0] + 1'b1) : t_word'(m[WORD_BITS-1:0]);
        return s;
    endfunction

endpackage

@@ design/fpa_req_if.sv @@
// Request channel: opcode and two operands.
`timescale 1ns / 1ps
interface fpa_req_if;
    import fpa_pkg::*;
    logic  valid;
    logic  ready;
    t_op   req_type;
    t_word operand_a;
    t_word operand_b;
    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

@@ design/fpa_rsp_if.sv @@
// Response channel: result word and flags.
`timescale 1ns / 1ps
interface fpa_rsp_if;
    import fpa_pkg::*;
    logic  valid;
    logic  ready;
    t_word result_value;
    logic  compare_true;
    logic  overflowed;
    logic  divide_by_zero;
    modport source (output valid, result_value, compare_true, overflowed, divide_by_zero,
                    input ready);
    modport sink   (input valid, result_value, compare_true, overflowed, divide_by_zero,
                    output ready);
endinterface

@@ design/fixed_point_alu.sv @@
// Top level of the pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
// Signed Q24.8 ALU on 32-bit raw words: add, sub, mul, div, six compares, min,
// max, inc, dec, to_int (floor) and from_int. Mul and div round half away from
// zero; overflow saturates and sets overflowed; divide by zero gives 0 with
// divide_by_zero set. One word is taken every cycle unless the pipe holds; each
// word passes an input stage, DIV_STG divider stages each resolving DIV_BPS
// quotient bits of the 40-bit scaled dividend (Q24.8 magnitude shifted left by
// FRAC_BITS) and a rounding/saturating output register. All opcodes take the
// same path, so results come out in order. The pipe moves as a whole: it holds
// only while the output register is full and the sink is not ready.
module fixed_point_alu (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_req_if.sink   i_req,
    fpa_rsp_if.source o_rsp
);
    import fpa_pkg::*;

    logic                   en;
    t_carry                 n_pipe0;
    t_div                   n_div0;
    t_carry                 r_pipe [0:DIV_STG];
    logic                   r_vld  [0:DIV_STG];
    t_div                   w_div  [0:DIV_STG];
    t_div                   r_div0;
    t_mag                   r_mag_a;
    t_mag                   r_mag_b;
    logic [2*WORD_BITS-1:0] r_prod;
    t_sat                   n_mul;
    t_carry                 n_pipe2;
    t_carry                 n_out;
    t_carry                 r_out;
    logic                   r_out_v;

    t_mag                   mag_a;
    t_mag                   mag_b;
    logic signed [WORD_BITS:0] ext_a;
    logic signed [WORD_BITS:0] ext_b;
    logic signed [WORD_BITS:0] sum;
    logic                   round_up;
    logic [SAT_W-1:0]       q_mag;
    t_sat                   q_sat;
    t_sat                   fi_sat;
    t_op                    op;

    assign en          = !r_out_v || o_rsp.ready;
    assign i_req.ready = en;

    // input stage: simple ops finish here
    always_comb begin
        op     = i_req.req_type;
        mag_a  = mag_of(i_req.operand_a);
        mag_b  = mag_of(i_req.operand_b);
        ext_a  = {i_req.operand_a[WORD_BITS-1], i_req.operand_a};
        ext_b  = (op == OP_INC || op == OP_DEC) ? (WORD_BITS+1)'(1)
                                               : {i_req.operand_b[WORD_BITS-1], i_req.operand_b};
        sum    = (op == OP_SUB || op == OP_DEC) ? ext_a - ext_b : ext_a + ext_b;
        fi_sat = sat_mag(SAT_W'(mag_a) << FRAC_BITS, i_req.operand_a[WORD_BITS-1]);

        n_pipe0       = '0;
        n_pipe0.op    = op;
        n_pipe0.neg   = i_req.operand_a[WORD_BITS-1] ^ i_req.operand_b[WORD_BITS-1];
        case (op)
            OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
                    n_pipe0.ov    = 1'b1;
                    n_pipe0.value = sum[WORD_BITS] ? t_word'({1'b1, {(WORD_BITS-1){1'b0}}})
                                                   : t_word'({1'b0, {(WORD_BITS-1){1'b1}}});
                end else begin
                    n_pipe0.value = sum[WORD_BITS-1:0];
                end
            end
            OP_DIV:  n_pipe0.dz  = (i_req.operand_b == '0);
            OP_GT:   n_pipe0.cmp = i_req.operand_a >  i_req.operand_b;
            OP_LT:   n_pipe0.cmp = i_req.operand_a <  i_req.operand_b;
            OP_GE:   n_pipe0.cmp = i_req.operand_a >= i_req.operand_b;
            OP_LE:   n_pipe0.cmp = i_req.operand_a <= i_req.operand_b;
            OP_EQ:   n_pipe0.cmp = i_req.operand_a == i_req.operand_b;
            OP_NE:   n_pipe0.cmp = i_req.operand_a != i_req.operand_b;
            OP_MIN:  n_pipe0.value = (i_req.operand_a < i_req.operand_b) ? i_req.operand_a
                                                                         : i_req.operand_b;
            OP_MAX:  n_pipe0.value = (i_req.operand_a > i_req.operand_b) ? i_req.operand_a
                                                                         : i_req.operand_b;
            OP_TO_INT: n_pipe0.value = i_req.operand_a >>> FRAC_BITS;
            OP_FROM_INT: begin
                n_pipe0.value = fi_sat.value;
                n_pipe0.ov    = fi_sat.ov;
            end
            default: n_pipe0.value = '0; // mul filled in later
        endcase

        // divisor of zero is harmless here, the flag overrides the quotient
        n_div0.rem = '0;
        n_div0.sh  = NUM_PAD'(mag_a) << FRAC_BITS;
        n_div0.den = mag_b;
    end

    // multiply: product at stage 1, round and saturate into stage 2
    always_comb begin
        n_mul   = sat_mag(({1'b0, r_prod} + (SAT_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS,
                          r_pipe[1].neg);
        n_pipe2 = r_pipe[1];
        if (r_pipe[1].op == OP_MUL) begin
            n_pipe2.value = n_mul.value;
            n_pipe2.ov    = n_mul.ov;
        end
    end

    assign w_div[0] = r_div0;

    for (genvar k = 1; k <= DIV_STG; k++) begin : g_div
        fpa_div_stage u_stage (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_state (w_div[k-1]),
            .o_state (w_div[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_STG; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_req.valid;
            for (int k = 1; k <= DIV_STG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_v <= r_vld[DIV_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pipe[0] <= n_pipe0;
            r_div0    <= n_div0;
            r_mag_a   <= mag_a;
            r_mag_b   <= mag_b;
            r_prod    <= r_mag_a * r_mag_b;
            for (int k = 1; k <= DIV_STG; k++) begin
                r_pipe[k] <= (k == 2) ? n_pipe2 : r_pipe[k-1];
            end
            r_out <= n_out;
        end
    end

    // divide: round half away on the remainder, then saturate
    always_comb begin
        round_up = {w_div[DIV_STG].rem, 1'b0} >= {1'b0, w_div[DIV_STG].den};
        q_mag    = SAT_W'(w_div[DIV_STG].sh) + SAT_W'(round_up);
        q_sat    = sat_mag(q_mag, r_pipe[DIV_STG].neg);
        n_out    = r_pipe[DIV_STG];
        if (r_pipe[DIV_STG].op == OP_DIV && !r_pipe[DIV_STG].dz) begin
            n_out.value = q_sat.value;
            n_out.ov    = q_sat.ov;
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.result_value   = r_out.value;
    assign o_rsp.compare_true   = r_out.cmp;
    assign o_rsp.overflowed     = r_out.ov;
    assign o_rsp.divide_by_zero = r_out.dz;
endmodule

@@ design/fpa_div_stage.sv @@
// One registered stage of the restoring divider, DIV_BPS quotient bits.
`timescale 1ns / 1ps
module fpa_div_stage (
    input  logic          i_clk,
    input  logic          i_en,
    input  fpa_pkg::t_div i_state,
    output fpa_pkg::t_div o_state
);
    import fpa_pkg::*;

    t_div                 n_state;
    t_div                 r_state;
    logic [WORD_BITS:0]   trial;

    always_comb begin
        n_state = i_state;
        trial   = '0;
        for (int i = 0; i < DIV_BPS; i++) begin
            trial      = {n_state.rem, n_state.sh[NUM_PAD-1]};
            n_state.sh = {n_state.sh[NUM_PAD-2:0], 1'b0};
            if (trial >= {1'b0, n_state.den}) begin
                trial         = trial - {1'b0, n_state.den};
                n_state.sh[0] = 1'b1;
            end
            n_state.rem = trial[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
endmodule
